### src/lifo_pkg.sv
package lifo_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned FILL_W     = $clog2(DEPTH + 1);
  localparam int unsigned OP_W       = 3;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned ERR_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_REPLACE = 3'd3,
    OP_SWAP    = 3'd4,
    OP_DROP    = 3'd5,
    OP_CLEAR   = 3'd6
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2
  } err_e;

  typedef struct packed {
    logic [FILL_W-1:0]     fill_d;
    err_e                  err;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  rd_en;
    logic [ADDR_W-1:0]     raddr;
  } ctrl_t;

endpackage

### src/lifo_if.sv
interface lifo_req_if;
  logic                               valid;
  logic                               ready;
  logic [lifo_pkg::OP_W-1:0]          op;
  logic [lifo_pkg::DATA_WIDTH-1:0]    value;
  logic [lifo_pkg::COUNT_W-1:0]       count;

  modport source (output valid, output op, output value, output count, input ready);
  modport sink   (input valid, input op, input value, input count, output ready);
endinterface

interface lifo_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [lifo_pkg::DATA_WIDTH-1:0]    data_out;
  logic [lifo_pkg::ERR_W-1:0]         error;
  logic [lifo_pkg::FILL_W-1:0]        fill;
  logic                               is_empty;

  modport source (output valid, output data_out, output error, output fill,
                  output is_empty, input ready);
  modport sink   (input valid, input data_out, input error, input fill,
                  input is_empty, output ready);
endinterface

### src/lifo_decode.sv
module lifo_decode (
  input  logic [lifo_pkg::OP_W-1:0]       op_i,
  input  logic [lifo_pkg::DATA_WIDTH-1:0] value_i,
  input  logic [lifo_pkg::COUNT_W-1:0]    count_i,
  input  logic [lifo_pkg::FILL_W-1:0]     fill_i,
  output lifo_pkg::ctrl_t                 ctrl_o
);

  localparam int unsigned DropW =
    (lifo_pkg::FILL_W > lifo_pkg::COUNT_W) ? lifo_pkg::FILL_W : lifo_pkg::COUNT_W;

  logic                          empty;
  logic                          full;
  logic [lifo_pkg::ADDR_W-1:0]   top;
  logic [DropW-1:0]              fill_ext;
  logic [DropW-1:0]              cnt_ext;
  logic [DropW-1:0]              drop_rem;

  assign empty    = (fill_i == '0);
  assign full     = (fill_i == lifo_pkg::FILL_W'(lifo_pkg::DEPTH));
  assign top      = lifo_pkg::ADDR_W'(fill_i - lifo_pkg::FILL_W'(1));
  assign fill_ext = DropW'(fill_i);
  assign cnt_ext  = DropW'(count_i);
  assign drop_rem = fill_ext - cnt_ext;

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.fill_d = fill_i;
    ctrl_o.err    = lifo_pkg::ERR_NONE;
    ctrl_o.wdata  = value_i;
    ctrl_o.raddr  = top;
    ctrl_o.waddr  = top;
    case (lifo_pkg::op_e'(op_i))
      lifo_pkg::OP_PUSH: begin
        if (full) begin
          ctrl_o.err = lifo_pkg::ERR_OVER;
        end else begin
          ctrl_o.we     = 1'b1;
          ctrl_o.waddr  = lifo_pkg::ADDR_W'(fill_i);
          ctrl_o.fill_d = fill_i + lifo_pkg::FILL_W'(1);
        end
      end
      lifo_pkg::OP_POP: begin
        if (empty) begin
          ctrl_o.err = lifo_pkg::ERR_UNDER;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.fill_d = fill_i - lifo_pkg::FILL_W'(1);
        end
      end
      lifo_pkg::OP_PEEK: begin
        if (empty) begin
          ctrl_o.err = lifo_pkg::ERR_UNDER;
        end else begin
          ctrl_o.rd_en = 1'b1;
        end
      end
      lifo_pkg::OP_REPLACE: begin
        if (empty) begin
          ctrl_o.err = lifo_pkg::ERR_UNDER;
        end else begin
          ctrl_o.we = 1'b1;
        end
      end
      lifo_pkg::OP_SWAP: begin
        if (empty) begin
          ctrl_o.err = lifo_pkg::ERR_UNDER;
        end else begin
          ctrl_o.rd_en = 1'b1;
          ctrl_o.we    = 1'b1;
        end
      end
      lifo_pkg::OP_DROP: begin
        if (cnt_ext > fill_ext) begin
          ctrl_o.fill_d = '0;
          ctrl_o.err    = lifo_pkg::ERR_UNDER;
        end else begin
          ctrl_o.fill_d = lifo_pkg::FILL_W'(drop_rem);
        end
      end
      lifo_pkg::OP_CLEAR: begin
        ctrl_o.fill_d = '0;
      end
      default: begin
        ctrl_o.fill_d = fill_i;
      end
    endcase
  end

endmodule

### src/lifo_stack_engine.sv
// Channel  Direction  Fields
// req_i    in         op, value, count
// rsp_o    out        data_out, error, fill, is_empty
//
// One word is accepted per cycle while the pending stage is free or moves on; its result
// word passes the pending stage and then the output register before it is offered.
// The fill count, all memory writes and the top-entry read update at the accepting edge.
// Reset clears the fill count and both result stages; the entry memory is not cleared.
// A stalled result holds in the output register while one more word waits behind it.
module lifo_stack_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  lifo_req_if.sink       req_i,
  lifo_rsp_if.source     rsp_o
);

  logic [lifo_pkg::DATA_WIDTH-1:0] mem [lifo_pkg::DEPTH];
  logic [lifo_pkg::DATA_WIDTH-1:0] rd_data_q;

  logic [lifo_pkg::FILL_W-1:0]     fill_q;
  lifo_pkg::ctrl_t                 ctrl;
  logic                            req_acc;

  logic                            p_valid_q;
  logic                            p_use_rd_q;
  lifo_pkg::err_e                  p_err_q;
  logic [lifo_pkg::FILL_W-1:0]     p_fill_q;
  logic                            p_move;

  logic                            o_valid_q;
  logic [lifo_pkg::DATA_WIDTH-1:0] o_data_q;
  lifo_pkg::err_e                  o_err_q;
  logic [lifo_pkg::FILL_W-1:0]     o_fill_q;

  lifo_decode u_decode (
    .op_i    (req_i.op),
    .value_i (req_i.value),
    .count_i (req_i.count),
    .fill_i  (fill_q),
    .ctrl_o  (ctrl)
  );

  assign p_move      = p_valid_q && (!o_valid_q || rsp_o.ready);
  assign req_i.ready = !p_valid_q || p_move;
  assign req_acc     = req_i.valid && req_i.ready;

  // Read data is the entry's old value when a swap writes the same address.
  always_ff @(posedge clk_i) begin
    if (req_acc && ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    if (req_acc && ctrl.rd_en) begin
      rd_data_q <= mem[ctrl.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (req_acc) begin
        fill_q <= ctrl.fill_d;
      end
      if (req_acc) begin
        p_valid_q <= 1'b1;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
      end
      if (p_move) begin
        o_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      p_use_rd_q <= ctrl.rd_en;
      p_err_q    <= ctrl.err;
      p_fill_q   <= ctrl.fill_d;
    end
    if (p_move) begin
      o_data_q <= p_use_rd_q ? rd_data_q : '0;
      o_err_q  <= p_err_q;
      o_fill_q <= p_fill_q;
    end
  end

  assign rsp_o.valid    = o_valid_q;
  assign rsp_o.data_out = o_data_q;
  assign rsp_o.error    = o_err_q;
  assign rsp_o.fill     = o_fill_q;
  assign rsp_o.is_empty = (o_fill_q == '0);

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= lifo_pkg::FILL_W'(lifo_pkg::DEPTH))
    else $error("fill count exceeds depth");

  a_full_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_i.op == lifo_pkg::OP_PUSH) &&
    (fill_q == lifo_pkg::FILL_W'(lifo_pkg::DEPTH)) |=> $stable(fill_q))
    else $error("push on a full stack changed the fill count");

  a_pend_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> p_valid_q && (p_fill_q == fill_q))
    else $error("accepted word not held in the pending stage");

endmodule
